@@ rtl/msp_pkg.sv @@
package msp_pkg;

  localparam int MSP_MAX_WIDTH  = 1024;
  localparam int MSP_MAX_HEIGHT = 1024;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;
  localparam int CFG_DIM_W  = 11;

  localparam logic [CFG_IDX_W-1:0] CFG_LINE_WIDTH   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BORDER_VALUE = 2'd2;

  localparam logic [CFG_DIM_W-1:0] LINE_WIDTH_RST   = 11'd480;
  localparam logic [CFG_DIM_W-1:0] FRAME_HEIGHT_RST = 11'd480;
  localparam logic                 BORDER_VALUE_RST = 1'b1;

  typedef struct packed {
    logic kind;
    logic pixel_in;
  } in_item_t;

  typedef struct packed {
    logic pixel_out;
    logic was_marked;
    logic frame_last;
  } out_item_t;

  // per-transaction info from the position counters to the window stage
  typedef struct packed {
    logic       step;
    logic       nb;
    logic       valid1;
    logic       valid2;
    logic       last;
    logic [7:0] mask1;
    logic [7:0] mask2;
  } pos_t;

  typedef struct packed {
    logic busy;
    logic has_result;
  } win_status_t;

  // shift a new column in on the right; row 0 is top, bits [2:0]
  function automatic logic [8:0] win_push(input logic [8:0] win, input logic top,
                                          input logic mid, input logic bot);
    return {win[7:6], bot, win[4:3], mid, win[1:0], top};
  endfunction

  // neighbor code NW,N,NE,W,E,SW,S,SE; masked positions take oval
  function automatic logic [7:0] nbr_code(input logic [8:0] win, input logic [7:0] omask,
                                          input logic oval);
    logic [7:0] raw;
    raw = {win[2], win[1], win[0], win[5], win[3], win[8], win[7], win[6]};
    return (raw & ~omask) | (omask & {8{oval}});
  endfunction

  // conditional pattern ROM
  function automatic logic cond_match(input logic [7:0] code);
    return code inside {
      8'h20, 8'h80, 8'h04, 8'h01, 8'h08, 8'h40, 8'h10, 8'h02,
      8'h28, 8'h60, 8'hC0, 8'h90, 8'h14, 8'h06, 8'h03, 8'h09,
      8'h29, 8'hE0, 8'h94, 8'h07, 8'hC8, 8'h49, 8'h70, 8'h2A,
      8'h68, 8'hD0, 8'h16, 8'h0B, 8'hC9, 8'h74,
      8'hE8, 8'h69, 8'hF0, 8'hD4, 8'h96, 8'h17, 8'h0F, 8'h2B,
      8'hE9, 8'hF4, 8'h97, 8'h2F, 8'h6B, 8'hF8, 8'hD6, 8'h1F,
      8'hEB, 8'h6F, 8'hFC, 8'hF9, 8'hF6, 8'hD7, 8'h9F, 8'h3F,
      8'hEF, 8'hFD, 8'hF7, 8'hBF
    };
  endfunction

  // unconditional pattern ROM
  function automatic logic unc_match(input logic [7:0] code);
    return code inside {
      8'h20, 8'h80, 8'h02, 8'h08,
      8'h28, 8'h60, 8'hC0, 8'h90, 8'h14, 8'h06, 8'h03, 8'h09,
      8'h70, 8'hC8, 8'h49, 8'h2A,
      8'h2C, 8'h91, 8'h26, 8'h83, 8'h64, 8'hC1, 8'h34, 8'h89,
      8'hD0, 8'hD1, 8'hD2, 8'hD3, 8'hD4, 8'hD5, 8'hD6, 8'hD7,
      8'hD8, 8'hD9, 8'hDA, 8'hDB, 8'hDC, 8'hDD, 8'hDE, 8'hDF,
      8'hF0, 8'hF1, 8'hF2, 8'hF3, 8'hF4, 8'hF5, 8'hF6, 8'hF7,
      8'hF8, 8'hF9, 8'hFA, 8'hFB, 8'hFC, 8'hFD, 8'hFE, 8'hFF,
      8'h58, 8'h1A, 8'h5C, 8'h59, 8'h1B, 8'h1E,
      8'h78, 8'h3A, 8'h9A, 8'h79, 8'h3B, 8'h9E,
      8'h52, 8'h4A, 8'h72, 8'h53, 8'h4B, 8'h6A,
      8'h56, 8'h4E, 8'hCA, 8'h57, 8'h4F, 8'hEA,
      8'hA1, 8'h85, 8'h25, 8'hA2, 8'h8C, 8'h45, 8'h31,
      8'hA4, 8'hA9, 8'h87, 8'h27,
      8'hAA, 8'h8E, 8'h47, 8'h33, 8'hAC, 8'hA6, 8'hA3,
      8'hB1, 8'h95, 8'h2D, 8'hB2, 8'h9C, 8'h4D, 8'h39,
      8'hB4, 8'h8D, 8'hB9, 8'h97, 8'h2F,
      8'hBA, 8'h4F, 8'h3B, 8'hBC, 8'hB6, 8'h8F, 8'hAB,
      8'hE1, 8'hC5, 8'h35, 8'h65, 8'hE2, 8'hCC, 8'h55, 8'h71,
      8'hE4, 8'h95, 8'hE9, 8'hC7, 8'h37, 8'h67,
      8'hEA, 8'hCE, 8'h57, 8'h73, 8'hEC, 8'hE6, 8'hE3,
      8'hF1, 8'hD5, 8'h3D, 8'h6D, 8'hF2, 8'hDC, 8'h5D, 8'h79,
      8'hF4, 8'h9D, 8'hF9, 8'hD7, 8'h3F, 8'h6F,
      8'hFA, 8'hDE, 8'h5F, 8'h7B, 8'hFC, 8'hF6, 8'h9F, 8'hEB,
      8'h4C, 8'h51, 8'h32, 8'h8A, 8'h4D, 8'h55, 8'h33, 8'h8E,
      8'hCC, 8'h71, 8'hB2, 8'hAA, 8'hCD, 8'h75, 8'hB3, 8'hAE
    };
  endfunction

endpackage

@@ rtl/msp_ram.sv @@
module msp_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ rtl/msp_pos.sv @@
module msp_pos import msp_pkg::*; #(
  parameter int MAX_WIDTH  = MSP_MAX_WIDTH,
  parameter int MAX_HEIGHT = MSP_MAX_HEIGHT
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         accept,
  input  in_item_t                     in_item,
  input  logic [CFG_DIM_W-1:0]         line_width,
  input  logic [CFG_DIM_W-1:0]         frame_height,
  input  logic                         border,
  output pos_t                         info,
  output logic [$clog2(MAX_WIDTH)-1:0] bit_addr,
  output logic [$clog2(MAX_WIDTH)-1:0] mark_addr
);

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int WD_W  = COL_W + 1;
  localparam int ROW_W = $clog2(MAX_HEIGHT + 3);
  localparam int RS_W  = ROW_W + 2;
  localparam int SW0   = (CFG_DIM_W > WD_W) ? CFG_DIM_W : WD_W;
  localparam int SAT_W = (SW0 > ROW_W) ? SW0 : ROW_W;

  localparam logic signed [RS_W-1:0] ZERO_S = '0;
  localparam logic signed [RS_W-1:0] ONE_S  = RS_W'(1);
  localparam logic signed [RS_W-1:0] TWO_S  = RS_W'(2);

  logic [COL_W-1:0]       col_r, col_nxt;
  logic [ROW_W-1:0]       row_r, row_nxt;
  logic [SAT_W-1:0]       lw_ext, fh_ext, wd_sat, ht_sat;
  logic [WD_W-1:0]        wd;
  logic [ROW_W-1:0]       ht, ht_p2;
  logic [COL_W-1:0]       c1, c2;
  logic signed [RS_W-1:0] row_s, ht_s, r1, r2;
  logic [2:0]             rf1, cf1, rf2, cf2;
  logic                   draining, last, step;

  // flags for rows r-1, r, r+1 falling outside the frame
  function automatic logic [2:0] row_flags(input logic signed [RS_W-1:0] r,
                                           input logic signed [RS_W-1:0] h);
    logic signed [RS_W-1:0] up, dn;
    up = r - ONE_S;
    dn = r + ONE_S;
    row_flags[0] = (up < ZERO_S) || (up >= h);
    row_flags[1] = (r < ZERO_S) || (r >= h);
    row_flags[2] = (dn < ZERO_S) || (dn >= h);
  endfunction

  function automatic logic [2:0] col_flags(input logic [COL_W-1:0] c,
                                           input logic [WD_W-1:0] w);
    logic [WD_W-1:0] ce;
    ce = {1'b0, c};
    col_flags[0] = (c == '0) || (ce > w);
    col_flags[1] = ce >= w;
    col_flags[2] = (ce + WD_W'(1)) >= w;
  endfunction

  function automatic logic [7:0] nbr_mask(input logic [2:0] rf, input logic [2:0] cf);
    return {rf[0] | cf[0], rf[0] | cf[1], rf[0] | cf[2],
            rf[1] | cf[0], rf[1] | cf[2],
            rf[2] | cf[0], rf[2] | cf[1], rf[2] | cf[2]};
  endfunction

  always_comb begin
    lw_ext = SAT_W'(line_width);
    fh_ext = SAT_W'(frame_height);
    if (lw_ext < SAT_W'(3)) begin
      wd_sat = SAT_W'(3);
    end else if (lw_ext > SAT_W'(MAX_WIDTH)) begin
      wd_sat = SAT_W'(MAX_WIDTH);
    end else begin
      wd_sat = lw_ext;
    end
    if (fh_ext < SAT_W'(3)) begin
      ht_sat = SAT_W'(3);
    end else if (fh_ext > SAT_W'(MAX_HEIGHT)) begin
      ht_sat = SAT_W'(MAX_HEIGHT);
    end else begin
      ht_sat = fh_ext;
    end
  end

  assign wd    = WD_W'(wd_sat);
  assign ht    = ROW_W'(ht_sat);
  assign ht_p2 = ht + ROW_W'(2);

  // window centers: stage one one pixel and one line back, stage two again
  assign c1 = (col_r != '0) ? col_r - COL_W'(1) : COL_W'(wd - WD_W'(1));
  assign c2 = (c1 != '0) ? c1 - COL_W'(1) : COL_W'(wd - WD_W'(1));

  assign row_s = $signed({2'b00, row_r});
  assign ht_s  = $signed({2'b00, ht});
  assign r1    = (col_r != '0) ? row_s - ONE_S : row_s - TWO_S;
  assign r2    = (c1 != '0) ? r1 - ONE_S : r1 - TWO_S;

  assign rf1 = row_flags(r1, ht_s);
  assign rf2 = row_flags(r2, ht_s);
  assign cf1 = col_flags(c1, wd);
  assign cf2 = col_flags(c2, wd);

  assign draining = row_r >= ht;
  assign last     = (row_r > ht_p2) || ((row_r == ht_p2) && (col_r != '0));
  // a flush tick before the frame is complete is dropped
  assign step     = accept && !(in_item.kind && !draining);

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (step) begin
      if (last) begin
        col_nxt = '0;
        row_nxt = '0;
      end else if (({1'b0, col_r} + WD_W'(1)) >= wd) begin
        col_nxt = '0;
        row_nxt = row_r + ROW_W'(1);
      end else begin
        col_nxt = col_r + COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  always_comb begin
    info.step   = step;
    info.nb     = draining ? border : in_item.pixel_in;
    info.valid1 = !rf1[1] && !cf1[1];
    info.valid2 = !rf2[1] && !cf2[1];
    info.last   = last;
    info.mask1  = nbr_mask(rf1, cf1);
    info.mask2  = nbr_mask(rf2, cf2);
  end

  assign bit_addr  = col_r;
  assign mark_addr = c1;

endmodule

@@ rtl/msp_win.sv @@
module msp_win import msp_pkg::*; #(
  parameter int MAX_WIDTH = MSP_MAX_WIDTH
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  pos_t                         info,
  input  logic [$clog2(MAX_WIDTH)-1:0] bit_addr,
  input  logic [$clog2(MAX_WIDTH)-1:0] mark_addr,
  input  logic                         border,
  input  logic                         commit,
  output win_status_t                  status,
  output out_item_t                    result
);

  localparam int COL_W = $clog2(MAX_WIDTH);

  logic             busy_r, busy_nxt;
  pos_t             item_r;
  logic [COL_W-1:0] bit_addr_r, mark_addr_r;
  logic             fwd_r;
  logic [2:0]       fwd_data_r;
  logic [8:0]       bit_win_r, mark_win_r, bit_win_nxt, mark_win_nxt;
  logic             slot_r;

  logic [1:0]       bit_rd;
  logic [2:0]       mark_ram_rd, mark_rd, mark_wdata;
  logic             cb, mark, m2, keep, cds_wr;

  assign busy_nxt = info.step ? 1'b1 : (commit ? 1'b0 : busy_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r     <= 1'b0;
      fwd_r      <= 1'b0;
      bit_win_r  <= '0;
      mark_win_r <= '0;
      slot_r     <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      if (info.step) begin
        // the line entry may be written at this very edge by the item ahead
        fwd_r <= commit && (mark_addr_r == mark_addr);
      end
      if (commit) begin
        bit_win_r  <= bit_win_nxt;
        mark_win_r <= mark_win_nxt;
        slot_r     <= mark_rd[0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (info.step) begin
      item_r      <= info;
      bit_addr_r  <= bit_addr;
      mark_addr_r <= mark_addr;
      fwd_data_r  <= mark_wdata;
    end
  end

  // bit lines: {two rows up, one row up}
  msp_ram #(
    .WIDTH(2),
    .DEPTH(MAX_WIDTH)
  ) u_bit_ram (
    .clk  (clk),
    .we   (commit),
    .waddr(bit_addr_r),
    .wdata({bit_rd[0], item_r.nb}),
    .re   (info.step),
    .raddr(bit_addr),
    .rdata(bit_rd)
  );

  // mark lines {two rows up, one row up} plus the delayed center bit
  msp_ram #(
    .WIDTH(3),
    .DEPTH(MAX_WIDTH)
  ) u_mark_ram (
    .clk  (clk),
    .we   (commit),
    .waddr(mark_addr_r),
    .wdata(mark_wdata),
    .re   (info.step),
    .raddr(mark_addr),
    .rdata(mark_ram_rd)
  );

  always_comb begin
    bit_win_nxt  = win_push(bit_win_r, bit_rd[1], bit_rd[0], item_r.nb);
    cb           = bit_win_nxt[4];
    mark         = item_r.valid1 && cb &&
                   cond_match(nbr_code(bit_win_nxt, item_r.mask1, border));
    mark_rd      = fwd_r ? fwd_data_r : mark_ram_rd;
    cds_wr       = item_r.valid1 && cb;
    mark_wdata   = {mark_rd[1], mark, cds_wr};
    mark_win_nxt = win_push(mark_win_r, mark_rd[2], mark_rd[1], mark);
    m2           = mark_win_nxt[4];
    keep         = m2 && unc_match(nbr_code(mark_win_nxt, item_r.mask2, 1'b0));
  end

  always_comb begin
    result.pixel_out  = m2 ? keep : slot_r;
    result.was_marked = m2;
    result.frame_last = item_r.last;
    status.busy       = busy_r;
    status.has_result = busy_r && item_r.valid2;
  end

endmodule

@@ rtl/morphological_shrink_pass.sv @@
// channel  direction  ports                               transaction when
// in       input      in_valid, in_stall, in_data         in_valid && !in_stall
// out      output     out_valid, out_stall, out_data      out_valid && !out_stall
// cfg      input      cfg_we, cfg_index, cfg_data         cfg_we
//
// One pixel or flush tick per cycle while in_stall is low; a result is registered
// as its item leaves the window stage. The rate is set by the single window stage,
// whose line RAMs are read at the transaction edge and written back as items leave.
// Reset clears counters, windows and handshake state; the line RAMs need no clear.
// in_stall rises only while the window stage holds an item with a result and
// the output register is full and stalled.
module morphological_shrink_pass import msp_pkg::*; #(
  parameter int MAX_WIDTH  = MSP_MAX_WIDTH,
  parameter int MAX_HEIGHT = MSP_MAX_HEIGHT
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_item_t             out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int COL_W = $clog2(MAX_WIDTH);

  logic [CFG_DIM_W-1:0] line_width_r, frame_height_r;
  logic                 border_r;
  logic                 out_valid_r;
  out_item_t            out_data_r;

  logic                 accept, s1_go;
  pos_t                 info;
  win_status_t          st;
  out_item_t            result;
  logic [COL_W-1:0]     bit_addr, mark_addr;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_width_r   <= LINE_WIDTH_RST;
      frame_height_r <= FRAME_HEIGHT_RST;
      border_r       <= BORDER_VALUE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_LINE_WIDTH: begin
          line_width_r <= CFG_DIM_W'(cfg_data);
        end
        CFG_FRAME_HEIGHT: begin
          frame_height_r <= CFG_DIM_W'(cfg_data);
        end
        CFG_BORDER_VALUE: begin
          border_r <= cfg_data[0];
        end
        default: begin
        end
      endcase
    end
  end

  assign s1_go    = st.busy && (!st.has_result || !out_valid_r || !out_stall);
  assign in_stall = st.busy && !s1_go;
  assign accept   = in_valid && !in_stall;

  msp_pos #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT)
  ) u_pos (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (accept),
    .in_item     (in_data),
    .line_width  (line_width_r),
    .frame_height(frame_height_r),
    .border      (border_r),
    .info        (info),
    .bit_addr    (bit_addr),
    .mark_addr   (mark_addr)
  );

  msp_win #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_win (
    .clk      (clk),
    .rst_n    (rst_n),
    .info     (info),
    .bit_addr (bit_addr),
    .mark_addr(mark_addr),
    .border   (border_r),
    .commit   (s1_go),
    .status   (st),
    .result   (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_go && st.has_result) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && st.has_result) begin
      out_data_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

@@ tb/sv/morphological_shrink_pass_tb.sv @@
module morphological_shrink_pass_tb;
  import msp_pkg::*;

  localparam int MW = MSP_MAX_WIDTH;
  localparam int MH = MSP_MAX_HEIGHT;
  localparam int CYCLE_LIMIT = 2000000;
  localparam int RANDOM_ITEMS = 1200;

  localparam logic KIND_PIXEL = 1'b0;
  localparam logic KIND_FLUSH = 1'b1;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  // stage one patterns, neighbor code NW,N,NE,W,E,SW,S,SE
  localparam COND_CODES = {
    8'h20, 8'h80, 8'h04, 8'h01, 8'h08, 8'h40, 8'h10, 8'h02,
    8'h28, 8'h60, 8'hC0, 8'h90, 8'h14, 8'h06, 8'h03, 8'h09,
    8'h29, 8'hE0, 8'h94, 8'h07, 8'hC8, 8'h49, 8'h70, 8'h2A,
    8'h68, 8'hD0, 8'h16, 8'h0B, 8'hC9, 8'h74,
    8'hE8, 8'h69, 8'hF0, 8'hD4, 8'h96, 8'h17, 8'h0F, 8'h2B,
    8'hE9, 8'hF4, 8'h97, 8'h2F, 8'h6B, 8'hF8, 8'hD6, 8'h1F,
    8'hEB, 8'h6F, 8'hFC, 8'hF9, 8'hF6, 8'hD7, 8'h9F, 8'h3F,
    8'hEF, 8'hFD, 8'hF7, 8'hBF
  };

  // stage two patterns over the mark image (repeats are harmless)
  localparam UNC_CODES = {
    8'h20, 8'h80, 8'h02, 8'h08,
    8'h28, 8'h60, 8'hC0, 8'h90, 8'h14, 8'h06, 8'h03, 8'h09,
    8'h70, 8'hC8, 8'h49, 8'h2A,
    8'h2C, 8'h91, 8'h26, 8'h83, 8'h64, 8'hC1, 8'h34, 8'h89,
    8'hD0, 8'hD1, 8'hD2, 8'hD3, 8'hD4, 8'hD5, 8'hD6, 8'hD7,
    8'hD8, 8'hD9, 8'hDA, 8'hDB, 8'hDC, 8'hDD, 8'hDE, 8'hDF,
    8'hF0, 8'hF1, 8'hF2, 8'hF3, 8'hF4, 8'hF5, 8'hF6, 8'hF7,
    8'hF8, 8'hF9, 8'hFA, 8'hFB, 8'hFC, 8'hFD, 8'hFE, 8'hFF,
    8'h58, 8'h58, 8'h1A, 8'h1A, 8'h5C, 8'h59, 8'h1B, 8'h1E,
    8'hD8, 8'h78, 8'h3A, 8'h9A, 8'hDC, 8'h79, 8'h3B, 8'h9E,
    8'h52, 8'h52, 8'h4A, 8'h4A, 8'h72, 8'h53, 8'h4B, 8'h6A,
    8'hD2, 8'h56, 8'h4E, 8'hCA, 8'hF2, 8'h57, 8'h4F, 8'hEA,
    8'hA1, 8'h85, 8'h25, 8'h25, 8'hA2, 8'h8C, 8'h45, 8'h31,
    8'hA4, 8'hA4, 8'h85, 8'hA1, 8'hA9, 8'h87, 8'h27, 8'h27,
    8'hAA, 8'h8E, 8'h47, 8'h33, 8'hAC, 8'hA6, 8'h87, 8'hA3,
    8'hB1, 8'h95, 8'h2D, 8'h2D, 8'hB2, 8'h9C, 8'h4D, 8'h39,
    8'hB4, 8'hB4, 8'h8D, 8'hA9, 8'hB9, 8'h97, 8'h2F, 8'h2F,
    8'hBA, 8'h9E, 8'h4F, 8'h3B, 8'hBC, 8'hB6, 8'h8F, 8'hAB,
    8'hE1, 8'hC5, 8'h35, 8'h65, 8'hE2, 8'hCC, 8'h55, 8'h71,
    8'hE4, 8'hE4, 8'h95, 8'hE1, 8'hE9, 8'hC7, 8'h37, 8'h67,
    8'hEA, 8'hCE, 8'h57, 8'h73, 8'hEC, 8'hE6, 8'h97, 8'hE3,
    8'hF1, 8'hD5, 8'h3D, 8'h6D, 8'hF2, 8'hDC, 8'h5D, 8'h79,
    8'hF4, 8'hF4, 8'h9D, 8'hE9, 8'hF9, 8'hD7, 8'h3F, 8'h6F,
    8'hFA, 8'hDE, 8'h5F, 8'h7B, 8'hFC, 8'hF6, 8'h9F, 8'hEB,
    8'h4C, 8'h51, 8'h32, 8'h8A, 8'h4D, 8'h55, 8'h33, 8'h8E,
    8'hCC, 8'h71, 8'hB2, 8'hAA, 8'hCD, 8'h75, 8'hB3, 8'hAE
  };

  // directed rows: item, then whether a result is due and its value
  typedef struct packed {
    logic      kind;
    logic      pix;
    logic      has;
    out_item_t res;
  } dir_row_t;

  localparam logic [5:0] ROW_SKIP    = {KIND_FLUSH, 1'b0, 1'b0, 3'b000};
  localparam logic [5:0] ROW_FILL    = {KIND_PIXEL, 1'b1, 1'b0, 3'b000};
  localparam logic [5:0] ROW_FILL_R  = {KIND_PIXEL, 1'b1, 1'b1, 3'b100};
  localparam logic [5:0] ROW_DRAIN   = {KIND_FLUSH, 1'b0, 1'b1, 3'b100};
  localparam logic [5:0] ROW_DRAIN_P = {KIND_PIXEL, 1'b0, 1'b1, 3'b100};
  localparam logic [5:0] ROW_LAST    = {KIND_FLUSH, 1'b0, 1'b1, 3'b101};

  // 3x3 all-ones frame, border 1: every code is all ones, nothing is marked,
  // so every pixel comes out as 1; results trail the input by 2*3+2 steps
  localparam logic [0:19][5:0] DIRECTED = {
    ROW_SKIP,
    ROW_FILL, ROW_FILL, ROW_FILL, ROW_FILL,
    ROW_SKIP,
    ROW_FILL, ROW_FILL, ROW_FILL, ROW_FILL,
    ROW_FILL_R,
    ROW_DRAIN, ROW_DRAIN, ROW_DRAIN,
    ROW_DRAIN_P,
    ROW_DRAIN, ROW_DRAIN, ROW_DRAIN,
    ROW_LAST,
    ROW_SKIP
  };

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  in_item_t              in_data = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_item_t             out_data;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  morphological_shrink_pass dut (
    .clk, .rst_n,
    .in_valid, .in_stall, .in_data,
    .out_valid, .out_stall, .out_data,
    .cfg_we, .cfg_index, .cfg_data
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // shrink state as seen by the predictor
  logic [CFG_DIM_W-1:0] cur_width = LINE_WIDTH_RST;
  logic [CFG_DIM_W-1:0] cur_height = FRAME_HEIGHT_RST;
  logic                 cur_border = BORDER_VALUE_RST;
  bit       line_hist [2][2][MW];   // [bits/marks][older/newer line][column]
  bit       center_dly [MW+2];
  bit [8:0] bit_win, mark_win;
  int       col_pos, row_pos;
  bit       cond_rom [256];
  bit       unc_rom [256];

  out_item_t pending [$];
  bit        script_on = 1'b0;
  bit        script_has = 1'b0;
  out_item_t script_res = '0;

  int unsigned accepted, cycles, errs, results, marked, frame_ends;
  int unsigned frames, fed, skipped;
  bit          gaps_in;
  logic        stall_on = 1'b1;
  int          stall_left;
  bit          got;
  out_item_t   res_now, want;

  initial begin
    for (int k = 0; k < $bits(COND_CODES) / 8; k++) cond_rom[COND_CODES[k*8 +: 8]] = 1'b1;
    for (int k = 0; k < $bits(UNC_CODES) / 8; k++) unc_rom[UNC_CODES[k*8 +: 8]] = 1'b1;
  end

  function automatic int clamp_dim(input logic [CFG_DIM_W-1:0] raw, input int hi);
    if (raw < 3) return 3;
    if (raw > hi) return hi;
    return int'(raw);
  endfunction

  // window bit (row R, col C) sits at R*3 + 2 - C; outside positions read 'outside'
  function automatic bit [7:0] nbr_bits(input bit [8:0] w, input int r, input int c,
                                        input int wd, input int ht, input bit outside);
    bit [7:0] code;
    int       k, nr, nc;
    k = 7;
    for (int dr = -1; dr <= 1; dr++) begin
      for (int dc = -1; dc <= 1; dc++) begin
        if (dr != 0 || dc != 0) begin
          nr = r + dr;
          nc = c + dc;
          if (nr < 0 || nr >= ht || nc < 0 || nc >= wd) code[k] = outside;
          else code[k] = w[(1 + dr) * 3 + 1 - dc];
          k--;
        end
      end
    end
    return code;
  endfunction

  // push a new bottom bit into a two-line store and shift its column into the window
  task automatic roll(input int which, input int idx, input bit v, inout bit [8:0] w);
    bit t, m;
    t = line_hist[which][0][idx];
    m = line_hist[which][1][idx];
    line_hist[which][0][idx] = m;
    line_hist[which][1][idx] = v;
    w = {w[7:6], v, w[4:3], m, w[1:0], t};
  endtask

  task automatic shrink_step(input in_item_t it, output bit has, output out_item_t res);
    int wd, ht, ir, ic, r1, c1, r2, c2, idx1;
    bit nb, cb, mk, oc, m2, fin;
    has = 1'b0;
    res = '0;
    wd = clamp_dim(cur_width, MW);
    ht = clamp_dim(cur_height, MH);
    ir = row_pos;
    ic = col_pos;
    // flush ticks before the frame is complete do nothing
    if (ir < ht && it.kind == KIND_FLUSH) return;
    nb = (ir >= ht) ? cur_border : it.pixel_in;

    roll(0, ic % MW, nb, bit_win);
    r1 = (ic >= 1) ? ir - 1 : ir - 2;
    c1 = (ic >= 1) ? ic - 1 : wd - 1;
    cb = bit_win[4];
    mk = (r1 >= 0 && r1 < ht && c1 < wd) && cb &&
         cond_rom[nbr_bits(bit_win, r1, c1, wd, ht, cur_border)];

    // center bit waits one line plus one pixel for stage two
    idx1 = c1 % MW;
    oc = center_dly[MW];
    center_dly[MW] = center_dly[idx1];
    center_dly[idx1] = (r1 >= 0 && r1 < ht && c1 < wd) ? cb : 1'b0;

    roll(1, idx1, mk, mark_win);
    r2 = (c1 >= 1) ? r1 - 1 : r1 - 2;
    c2 = (c1 >= 1) ? c1 - 1 : wd - 1;
    fin = ir > ht + 2 || (ir == ht + 2 && ic >= 1);

    if (r2 >= 0 && r2 < ht && c2 < wd) begin
      m2 = mark_win[4];
      res.pixel_out = m2 ? unc_rom[nbr_bits(mark_win, r2, c2, wd, ht, 1'b0)] : oc;
      res.was_marked = m2;
      res.frame_last = fin;
      has = 1'b1;
    end

    if (fin) begin
      col_pos = 0;
      row_pos = 0;
    end else if (ic + 1 >= wd) begin
      col_pos = 0;
      row_pos = ir + 1;
    end else begin
      col_pos = ic + 1;
    end
  endtask

  task automatic report(input string what, input int seen_v, input int want_v);
    if (errs < 40) $display("ERROR @%0t: %s is %0d, expected %0d", $time, what, seen_v, want_v);
    errs++;
  endtask

  // predictor and checker, both on pre-edge values
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_LINE_WIDTH:   cur_width = cfg_data;
          CFG_FRAME_HEIGHT: cur_height = cfg_data;
          CFG_BORDER_VALUE: cur_border = cfg_data[0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (pending.size() == 0) begin
          report("unexpected result, pixel_out", out_data.pixel_out, 0);
        end else begin
          want = pending.pop_front();
          if (out_data.pixel_out !== want.pixel_out)
            report("pixel_out", out_data.pixel_out, want.pixel_out);
          if (out_data.was_marked !== want.was_marked)
            report("was_marked", out_data.was_marked, want.was_marked);
          if (out_data.frame_last !== want.frame_last)
            report("frame_last", out_data.frame_last, want.frame_last);
        end
        results++;
        if (out_data.was_marked === 1'b1) marked++;
        if (out_data.frame_last === 1'b1) frame_ends++;
      end
      if (in_valid && !in_stall) begin
        shrink_step(in_data, got, res_now);
        if (script_on) begin
          got = script_has;
          res_now = script_res;
        end
        if (got) pending.push_back(res_now);
        accepted++;
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout with %0d results outstanding", pending.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
    end else if (stall_on && $urandom_range(0, 3) == 0) begin
      out_stall <= 1'b1;
      stall_left <= idle_len();
    end else begin
      out_stall <= 1'b0;
      stall_left <= $urandom_range(0, 5);
    end
  end

  // called at a falling edge; returns at the falling edge after the transaction
  task automatic push_item(input in_item_t it);
    int unsigned seen;
    seen = accepted;
    in_valid <= 1'b1;
    in_data <= it;
    do @(negedge clk); while (accepted == seen);
  endtask

  task automatic send(input logic kind, input logic pix);
    in_item_t it;
    int       n;
    it.kind = kind;
    it.pixel_in = pix;
    push_item(it);
    n = idle_len();
    if (gaps_in && n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(negedge clk);
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
  endtask

  task automatic set_shape(input logic [CFG_DATA_W-1:0] w, input logic [CFG_DATA_W-1:0] h,
                           input logic b);
    write_reg(CFG_LINE_WIDTH, w);
    write_reg(CFG_FRAME_HEIGHT, h);
    write_reg(CFG_BORDER_VALUE, {{(CFG_DATA_W-1){1'b0}}, b});
    cfg_we <= 1'b0;
  endtask

  // full frame plus drain; stray flushes before completion and after the drain
  task automatic send_frame(input int fill_pct);
    int wd, ht;
    wd = clamp_dim(cur_width, MW);
    ht = clamp_dim(cur_height, MH);
    for (int p = 0; p < wd * ht; p++) begin
      if ($urandom_range(0, 39) == 0) begin
        send(KIND_FLUSH, 1'($urandom_range(0, 1)));
        skipped++;
      end
      send(KIND_PIXEL, $urandom_range(0, 99) < fill_pct);
    end
    for (int p = 0; p < 2 * wd + 2; p++)
      send(($urandom_range(0, 3) == 0) ? KIND_PIXEL : KIND_FLUSH, 1'($urandom_range(0, 1)));
    if ($urandom_range(0, 2) == 0) begin
      send(KIND_FLUSH, 1'($urandom_range(0, 1)));
      skipped++;
    end
    fed += wd * ht + 2 * wd + 2;
    frames++;
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  function automatic int pick_fill();
    case ($urandom_range(0, 3))
      0: return 8;
      1: return 50;
      2: return 85;
      default: return 97;
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_dim(input int hi);
    if ($urandom_range(0, 9) == 0) return CFG_DATA_W'($urandom_range(0, 2));
    return CFG_DATA_W'($urandom_range(3, hi));
  endfunction

  initial begin
    dir_row_t    row;
    in_item_t    it;
    int unsigned rand_start;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // widths below the minimum saturate to 3; the spare index is ignored
    write_reg(CFG_LINE_WIDTH, 11'd0);
    write_reg(CFG_FRAME_HEIGHT, 11'd2);
    write_reg(CFG_BORDER_VALUE, 11'd1);
    write_reg(CFG_SPARE, 11'h7FF);
    cfg_we <= 1'b0;
    for (int i = 0; i < 20; i++) begin
      row = DIRECTED[i];
      script_on <= 1'b1;
      script_has <= row.has;
      script_res <= row.res;
      it.kind = row.kind;
      it.pixel_in = row.pix;
      push_item(it);
    end
    script_on <= 1'b0;
    wait_idle();
    frames = 1;

    rand_start = fed;
    while (fed - rand_start < RANDOM_ITEMS) begin
      set_shape(pick_dim(20), pick_dim(12), 1'($urandom_range(0, 1)));
      gaps_in = $urandom_range(0, 3) != 0;
      stall_on <= $urandom_range(0, 3) != 0;
      repeat ($urandom_range(1, 3)) send_frame(pick_fill());
      wait_idle();
    end
    repeat (8) @(negedge clk);

    $display("fed %0d frames, %0d pixel/flush transactions plus %0d stray flushes",
             frames, fed, skipped);
    $display("checked %0d results: %0d marked in stage one, %0d frame ends",
             results, marked, frame_ends);
    if (errs == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
